// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/utr_pkg.sv -----
`timescale 1ns / 1ps

package utr_pkg;

   localparam int CODE_W = 21;
   localparam int SLOTS  = 3;

   // Thai code points that steer the reordering
   localparam logic [CODE_W-1:0] TONE_FIRST      = 21'h000E48;
   localparam logic [CODE_W-1:0] TONE_REMAP_LAST = 21'h000E4C;
   localparam logic [CODE_W-1:0] TONE_LAST       = 21'h000E4D;
   localparam logic [CODE_W-1:0] UPPER_MAI_HAN   = 21'h000E31;
   localparam logic [CODE_W-1:0] UPPER_RUN_FIRST = 21'h000E34;
   localparam logic [CODE_W-1:0] UPPER_RUN_LAST  = 21'h000E37;
   localparam logic [CODE_W-1:0] UPPER_MAITAIKHU = 21'h000E47;
   localparam logic [CODE_W-1:0] LOWER_SARA_U    = 21'h000E38;
   localparam logic [CODE_W-1:0] LOWER_SARA_UU   = 21'h000E39;
   localparam logic [CODE_W-1:0] REMAP_BASE      = 21'h00F70A;

   // UTF-8 lead byte prefixes
   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] CONT  = 8'h80;

   // One input byte's worth of finished glyphs, in output order
   typedef struct packed {
      logic [SLOTS-1:0][CODE_W-1:0] code;
      logic [1:0]                   count;
      logic                         last;
   } utr_entry_type;

endpackage

// ----- rtl/utr_front.sv -----
`timescale 1ns / 1ps

module utr_front import utr_pkg::*; #(
   parameter int MAX_GLYPHS = 127
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_in_byte,
   input  logic          req_in_last,
   input  logic          q_ready,
   output logic          q_push,
   output utr_entry_type q_entry
);

   localparam int CW = $clog2(MAX_GLYPHS + 1);

   function automatic logic is_tone(input logic [CODE_W-1:0] c);
      return (c >= TONE_FIRST) && (c <= TONE_LAST);
   endfunction

   function automatic logic is_upper(input logic [CODE_W-1:0] c);
      return (c == UPPER_MAI_HAN) || (c == UPPER_MAITAIKHU) ||
             ((c >= UPPER_RUN_FIRST) && (c <= UPPER_RUN_LAST));
   endfunction

   function automatic logic is_lower(input logic [CODE_W-1:0] c);
      return (c == LOWER_SARA_U) || (c == LOWER_SARA_UU);
   endfunction

   logic [CODE_W-1:0] part_ff, part_in;
   logic [1:0]        pend_ff, pend_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              halt_ff, halt_in;
   logic              uv_ff, uv_in;
   logic [CODE_W-1:0] uc_ff, uc_in;
   logic              lv_ff, lv_in;
   logic [CODE_W-1:0] lc_ff, lc_in;
   logic              puv_ff, puv_in;
   logic              accept;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;

   // decode, both carry stages and the remap, all for one input byte
   always_comb begin
      logic              take;
      logic [CODE_W-1:0] tv;
      logic              g_ok;
      logic [CODE_W-1:0] lin [2];
      logic [1:0]        ln;
      logic [CODE_W-1:0] fin [SLOTS];
      logic [1:0]        fn;
      logic [CODE_W-1:0] h;
      logic [CODE_W-1:0] c;

      part_in = part_ff;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      halt_in = halt_ff;
      uv_in   = uv_ff;
      uc_in   = uc_ff;
      lv_in   = lv_ff;
      lc_in   = lc_ff;
      puv_in  = puv_ff;
      take    = 1'b0;
      tv      = '0;
      g_ok    = 1'b0;
      ln      = 2'd0;
      fn      = 2'd0;
      h       = '0;
      c       = '0;
      for (int i = 0; i < 2; i++) lin[i] = '0;
      for (int i = 0; i < SLOTS; i++) fin[i] = '0;

      // byte decoder
      if (!halt_ff) begin
         if (pend_ff != 2'd0) begin
            part_in = {part_ff[CODE_W-7:0], req_in_byte[5:0]};
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               take = 1'b1;
               tv   = part_in;
            end
         end else if (!req_in_byte[7]) begin
            take = 1'b1;
            tv   = {13'd0, req_in_byte};
         end else if (req_in_byte[7:5] == LEAD2[7:5]) begin
            part_in = {16'd0, req_in_byte[4:0]};
            pend_in = 2'd1;
         end else if (req_in_byte[7:4] == LEAD3[7:4]) begin
            part_in = {17'd0, req_in_byte[3:0]};
            pend_in = 2'd2;
         end else if (req_in_byte[7:3] == LEAD4[7:3]) begin
            part_in = {18'd0, req_in_byte[2:0]};
            pend_in = 2'd3;
         end else begin
            take = 1'b1;
            tv   = {13'd0, req_in_byte};
         end
      end

      // zero halts, glyph limit halts
      if (take) begin
         if (tv == '0) begin
            halt_in = 1'b1;
         end else begin
            g_ok   = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_in >= CW'(MAX_GLYPHS)) halt_in = 1'b1;
         end
      end

      // upper-vowel carry stage
      if (g_ok) begin
         if (uv_ff && is_upper(tv)) begin
            lin[ln[0]] = tv;
            ln = ln + 2'd1;
         end else begin
            if (uv_ff) begin
               lin[ln[0]] = uc_ff;
               ln = ln + 2'd1;
               uv_in = 1'b0;
            end
            if (is_tone(tv)) begin
               uv_in = 1'b1;
               uc_in = tv;
            end else begin
               lin[ln[0]] = tv;
               ln = ln + 2'd1;
            end
         end
      end
      if (req_in_last && uv_in) begin
         lin[ln[0]] = uc_in;
         ln = ln + 2'd1;
         uv_in = 1'b0;
      end

      // lower-vowel carry stage
      for (int i = 0; i < 2; i++) begin
         if (2'(i) < ln) begin
            h = lin[i];
            if (lv_in && is_lower(h)) begin
               fin[fn] = h;
               fn = fn + 2'd1;
            end else begin
               if (lv_in) begin
                  fin[fn] = lc_in;
                  fn = fn + 2'd1;
                  lv_in = 1'b0;
               end
               if (is_tone(h)) begin
                  lv_in = 1'b1;
                  lc_in = h;
               end else begin
                  fin[fn] = h;
                  fn = fn + 2'd1;
               end
            end
         end
      end
      if (req_in_last && lv_in) begin
         fin[fn] = lc_in;
         fn = fn + 2'd1;
         lv_in = 1'b0;
      end

      // tone remap after an upper vowel
      q_entry = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (2'(j) < fn) begin
            c = fin[j];
            if (is_tone(c) && puv_in && (c <= TONE_REMAP_LAST)) begin
               q_entry.code[j] = REMAP_BASE + {18'd0, c[2:0]};
            end else begin
               q_entry.code[j] = c;
            end
            puv_in = is_upper(c);
         end
      end
      q_entry.count = fn;
      q_entry.last  = req_in_last;

      // end of string clears the control state
      if (req_in_last) begin
         part_in = '0;
         pend_in = 2'd0;
         cnt_in  = '0;
         halt_in = 1'b0;
         uv_in   = 1'b0;
         lv_in   = 1'b0;
         puv_in  = 1'b0;
      end
   end

   assign q_push = accept && (q_entry.count != 2'd0);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
         pend_ff <= 2'd0;
         cnt_ff  <= '0;
         halt_ff <= 1'b0;
         uv_ff   <= 1'b0;
         lv_ff   <= 1'b0;
         puv_ff  <= 1'b0;
      end else if (accept) begin
         part_ff <= part_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         halt_ff <= halt_in;
         uv_ff   <= uv_in;
         lv_ff   <= lv_in;
         puv_ff  <= puv_in;
      end
   end

   // carried codes, qualified by their valid bits
   always_ff @(posedge clock) begin
      if (accept) begin
         uc_ff <= uc_in;
         lc_ff <= lc_in;
      end
   end

endmodule

// ----- rtl/utr_queue.sv -----
`timescale 1ns / 1ps

module utr_queue import utr_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  utr_entry_type push_entry,
   output logic          push_ready,
   input  logic          pop,
   output logic          pop_valid,
   output utr_entry_type pop_entry
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   utr_entry_type   slot_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [NW-1:0]   num_ff, num_in;
   logic            do_push, do_pop;

   assign push_ready = (num_ff != NW'(DEPTH));
   assign pop_valid  = (num_ff != '0);
   assign pop_entry  = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      num_in = num_ff;
      if (do_push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (do_pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (do_push && !do_pop) num_in = num_ff + NW'(1);
      if (!do_push && do_pop) num_in = num_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         num_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         num_ff <= num_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

// ----- rtl/utr_back.sv -----
`timescale 1ns / 1ps

module utr_back import utr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  utr_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_out_last
);

   // number of UTF-8 bytes for a code point, minus one
   function automatic logic [1:0] enc_span(input logic [CODE_W-1:0] c);
      if (c < 21'h000080)      return 2'd0;
      else if (c < 21'h000800) return 2'd1;
      else if (c < 21'h010000) return 2'd2;
      else                     return 2'd3;
   endfunction

   function automatic logic [7:0] enc_byte(input logic [CODE_W-1:0] c,
                                           input logic [1:0] span,
                                           input logic [1:0] idx);
      logic [7:0] b;
      b = CONT | {2'b00, c[5:0]};
      case (span)
         2'd0: b = c[7:0];
         2'd1: begin
            if (idx == 2'd0) b = LEAD2 | {3'b000, c[10:6]};
         end
         2'd2: begin
            if (idx == 2'd0)      b = LEAD3 | {4'b0000, c[15:12]};
            else if (idx == 2'd1) b = CONT | {2'b00, c[11:6]};
         end
         2'd3: begin
            if (idx == 2'd0)      b = LEAD4 | {5'b00000, c[20:18]};
            else if (idx == 2'd1) b = CONT | {2'b00, c[17:12]};
            else if (idx == 2'd2) b = CONT | {2'b00, c[11:6]};
         end
         default: b = c[7:0];
      endcase
      return b;
   endfunction

   utr_entry_type     ent_ff;
   logic              busy_ff, busy_in;
   logic [1:0]        gi_ff, gi_in;
   logic [1:0]        bi_ff, bi_in;
   logic [CODE_W-1:0] cur;
   logic [1:0]        span;
   logic              last_byte, last_glyph, fire, done;

   assign cur        = ent_ff.code[gi_ff];
   assign span       = enc_span(cur);
   assign last_byte  = (bi_ff == span);
   assign last_glyph = (gi_ff == ent_ff.count - 2'd1);

   assign rsp_valid    = busy_ff;
   assign rsp_out_byte = enc_byte(cur, span, bi_ff);
   assign rsp_out_last = ent_ff.last && last_byte && last_glyph;

   assign fire  = busy_ff && rsp_ready;
   assign done  = fire && last_byte && last_glyph;
   assign q_pop = q_valid && (!busy_ff || done);

   // walk glyphs and their bytes
   always_comb begin
      busy_in = busy_ff;
      gi_in   = gi_ff;
      bi_in   = bi_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         gi_in   = 2'd0;
         bi_in   = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         if (last_byte) begin
            gi_in = gi_ff + 2'd1;
            bi_in = 2'd0;
         end else begin
            bi_in = bi_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         gi_ff   <= 2'd0;
         bi_ff   <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         gi_ff   <= gi_in;
         bi_ff   <= bi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) ent_ff <= q_entry;
   end

endmodule

// ----- rtl/utf8_thai_mark_reorder.sv -----
`timescale 1ns / 1ps
// Thai tone-mark reordering on a UTF-8 byte stream. Input bytes arrive on the
// req_ channel, one per transaction, with req_in_last on the final byte of a
// string; reshaped bytes leave on the rsp_ channel with rsp_out_last on the
// final byte emitted for that string (a string whose result is empty shows
// no rsp_out_last). The front decodes and runs both tone carries in the cycle
// a byte is accepted, so it takes one byte per cycle while the glyph queue
// (QUEUE_DEPTH entries) has room. The back re-encodes and sends one byte per
// cycle while rsp_ready is high; an input byte that completes up to three
// glyphs produces up to ten output bytes, during which the front keeps filling
// the queue. A finished entry passes through the queue and the back's entry
// register before its first byte appears. No clearing pass after reset.

module utf8_thai_mark_reorder import utr_pkg::*; #(
   parameter int MAX_GLYPHS  = 127,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   utr_entry_type push_entry, pop_entry;
   logic          push, push_ready, pop, pop_valid;

   utr_front #(
      .MAX_GLYPHS(MAX_GLYPHS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in_byte(req_in_byte),
      .req_in_last(req_in_last),
      .q_ready    (push_ready),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   utr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .push_ready(push_ready),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry)
   );

   utr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (pop_valid),
      .q_entry     (pop_entry),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last)
   );

endmodule

// ----- rtl/utr_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // stalled output holds its byte
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last), "rsp changed while stalled")

   // string end never lands on a lead byte
   `ASSERT_SAME(a_last_not_lead, clock, reset, rsp_valid && rsp_out_last, rsp_out_byte[7:6] != 2'b11, "rsp_out_last on a lead byte")

   // a lead byte is followed at once by a continuation byte
   `ASSERT_NEXT(a_lead_then_cont, clock, reset, rsp_valid && rsp_ready && (rsp_out_byte[7:6] == 2'b11), rsp_valid && (rsp_out_byte[7:6] == 2'b10), "lead byte not followed by continuation")

   // zero glyphs are never emitted
   `ASSERT_SAME(a_no_zero, clock, reset, rsp_valid, rsp_out_byte != 8'h00, "zero byte emitted")

   // input only backs up while output is pending
   `ASSERT_SAME(a_stall_has_output, clock, reset, req_valid && !req_ready, rsp_valid, "input stalled with no output pending")

endmodule

bind utf8_thai_mark_reorder utr_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_byte(rsp_out_byte),
   .rsp_out_last(rsp_out_last)
);
